@@ design/sts_pkg.sv @@
`default_nettype none

package sts_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned LEN_W  = 7;

  // Request codes.
  localparam logic [1:0] REQ_PUSH  = 2'd0;
  localparam logic [1:0] REQ_POP   = 2'd1;
  localparam logic [1:0] REQ_CLEAR = 2'd2;

  // Result status codes.
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic [1:0]               req_type;
    logic                     stack_sel;
    logic signed [DATA_W-1:0] push_value;
  } sts_in_t;

  typedef struct packed {
    logic [1:0]               status;
    logic signed [DATA_W-1:0] pop_value;
    logic [LEN_W-1:0]         lower_depth;
    logic [LEN_W-1:0]         upper_depth;
    logic [LEN_W-1:0]         total_length;
    logic                     all_empty;
  } sts_out_t;

  typedef struct packed {
    logic load_req;
    logic exec;
    logic load_out;
  } sts_cmd_t;

  typedef struct packed {
    logic out_free;
  } sts_stat_t;

endpackage

`default_nettype wire

@@ design/sts_ram.sv @@
`default_nettype none

module sts_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

`default_nettype wire

@@ design/sts_ctrl.sv @@
`default_nettype none

module sts_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire sts_pkg::sts_stat_t stat,
  output sts_pkg::sts_cmd_t      cmd
);

  import sts_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_DONE
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   in_ready_r;
  logic   in_ready_nxt;

  always_comb begin
    state_nxt    = state_r;
    in_ready_nxt = in_ready_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready_r) begin
          state_nxt    = S_EXEC;
          in_ready_nxt = 1'b0;
        end
      end
      S_EXEC: begin
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (stat.out_free) begin
          state_nxt    = S_IDLE;
          in_ready_nxt = 1'b1;
        end
      end
      default: begin
        state_nxt    = S_IDLE;
        in_ready_nxt = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      in_ready_r <= 1'b1;
    end else begin
      state_r    <= state_nxt;
      in_ready_r <= in_ready_nxt;
    end
  end

  assign in_ready     = in_ready_r;
  assign cmd.load_req = in_valid && in_ready_r;
  assign cmd.exec     = (state_r == S_EXEC);
  assign cmd.load_out = (state_r == S_DONE) && stat.out_free;

`ifndef NO_ASSERTIONS
  a_ready_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready_r |-> state_r == S_IDLE)
    else $error("input ready outside idle state");

  a_exec_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_req |=> state_r == S_EXEC)
    else $error("accepted item not executed in the next cycle");

  a_exec_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_EXEC |=> state_r == S_DONE)
    else $error("execute state did not advance to done");
`endif

endmodule

`default_nettype wire

@@ design/sts_dp.sv @@
`default_nettype none

module sts_dp #(
  parameter int unsigned DEPTH = 64
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire sts_pkg::sts_in_t  in_data,
  input  wire sts_pkg::sts_cmd_t cmd,
  output sts_pkg::sts_stat_t     stat,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output sts_pkg::sts_out_t      out_data
);

  import sts_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned EW = (CW > LEN_W) ? CW : LEN_W;
  localparam logic [CW:0]   DEPTH_S = (CW + 1)'(DEPTH);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
  localparam logic [CW-1:0] ONE_C   = CW'(1);

  sts_in_t       req_r;
  logic [CW-1:0] lower_r;
  logic [CW-1:0] lower_nxt;
  logic [CW-1:0] upper_r;
  logic [CW-1:0] upper_nxt;
  logic [1:0]    status_r;
  logic [1:0]    status_nxt;
  logic          pop_ok_r;
  logic          pop_ok_nxt;
  logic          out_valid_r;
  sts_out_t      out_data_r;

  logic [CW:0]       sum;
  logic              full;
  logic              ram_we;
  logic              ram_re;
  logic [CW-1:0]     addr_full;
  logic [DATA_W-1:0] ram_rdata;
  logic [EW-1:0]     lower_ext;
  logic [EW-1:0]     upper_ext;
  logic [EW:0]       total_ext;

  assign sum  = {1'b0, lower_r} + {1'b0, upper_r};
  assign full = (sum >= DEPTH_S);

  always_comb begin
    lower_nxt  = lower_r;
    upper_nxt  = upper_r;
    status_nxt = ST_OK;
    pop_ok_nxt = 1'b0;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    addr_full  = lower_r;
    case (req_r.req_type)
      REQ_PUSH: begin
        if (full) begin
          status_nxt = ST_FULL;
        end else if (!req_r.stack_sel) begin
          ram_we    = cmd.exec;
          addr_full = lower_r;
          lower_nxt = lower_r + ONE_C;
        end else begin
          ram_we    = cmd.exec;
          addr_full = DEPTH_C - (upper_r + ONE_C);
          upper_nxt = upper_r + ONE_C;
        end
      end
      REQ_POP: begin
        if (!req_r.stack_sel) begin
          if (lower_r == '0) begin
            status_nxt = ST_EMPTY;
          end else begin
            ram_re     = cmd.exec;
            pop_ok_nxt = 1'b1;
            addr_full  = lower_r - ONE_C;
            lower_nxt  = lower_r - ONE_C;
          end
        end else begin
          if (upper_r == '0) begin
            status_nxt = ST_EMPTY;
          end else begin
            ram_re     = cmd.exec;
            pop_ok_nxt = 1'b1;
            addr_full  = DEPTH_C - upper_r;
            upper_nxt  = upper_r - ONE_C;
          end
        end
      end
      REQ_CLEAR: begin
        lower_nxt = '0;
        upper_nxt = '0;
      end
      default: begin
      end
    endcase
  end

  sts_ram #(
    .WIDTH(DATA_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .re   (ram_re),
    .addr (addr_full[AW-1:0]),
    .wdata(req_r.push_value),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_r <= in_data;
    end
    if (cmd.exec) begin
      status_r <= status_nxt;
      pop_ok_r <= pop_ok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lower_r <= '0;
      upper_r <= '0;
    end else if (cmd.exec) begin
      lower_r <= lower_nxt;
      upper_r <= upper_nxt;
    end
  end

  // Depth fields report the counts modulo 128 when the store is deeper.
  assign lower_ext = EW'(lower_r);
  assign upper_ext = EW'(upper_r);
  assign total_ext = {1'b0, lower_ext} + {1'b0, upper_ext};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data_r.status       <= status_r;
      out_data_r.pop_value    <= pop_ok_r ? ram_rdata : '0;
      out_data_r.lower_depth  <= lower_ext[LEN_W-1:0];
      out_data_r.upper_depth  <= upper_ext[LEN_W-1:0];
      out_data_r.total_length <= total_ext[LEN_W-1:0];
      out_data_r.all_empty    <= (lower_r == '0) && (upper_r == '0);
    end
  end

  assign stat.out_free = !out_valid_r || out_ready;
  assign out_valid     = out_valid_r;
  assign out_data      = out_data_r;

`ifndef NO_ASSERTIONS
  a_never_overfull: assert property (@(posedge clk) disable iff (!rst_n)
    sum <= DEPTH_S)
    else $error("stacks hold more items than the store");

  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec && req_r.req_type == REQ_CLEAR |=> lower_r == '0 && upper_r == '0)
    else $error("clear did not empty both stacks");

  a_full_push_holds: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec && req_r.req_type == REQ_PUSH && full
    |=> $stable(lower_r) && $stable(upper_r))
    else $error("rejected push changed a stack depth");

  a_no_write_on_fail: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec && status_nxt != ST_OK |-> !ram_we && !ram_re)
    else $error("store accessed by a failed request");
`endif

endmodule

`default_nettype wire

@@ design/shared_two_ended_stack.sv @@
// Two LIFO stacks sharing one store of DEPTH words. The lower stack fills
// the store from entry zero upward and the upper stack from the last entry
// downward, so either may use all free space.
// Input channel: in_valid/in_ready carry one request item (push, pop or
// clear both, plus a stack select and the word to push). Result channel:
// out_valid/out_ready carry exactly one result item per request, with the
// status, the popped word and both depths after the request.
// A result item is loaded into the output register after its request
// is accepted and executed: the execute state updates the depth
// counters and accesses the store, the done state takes the registered
// store read. in_ready returns with that load, so the next request is
// accepted only after the previous result is loaded; requests do not
// overlap.
// When the receiver stalls, the finished result waits in the output
// register while the next request is accepted and executed; that request
// then waits until the output register frees.
// Reset empties both stacks; store contents are not cleared and need not be.
`default_nettype none

module shared_two_ended_stack #(
  parameter int unsigned DEPTH = 64
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire sts_pkg::sts_in_t  in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output sts_pkg::sts_out_t      out_data
);

  import sts_pkg::*;

  sts_cmd_t  cmd;
  sts_stat_t stat;

  sts_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .stat    (stat),
    .cmd     (cmd)
  );

  sts_dp #(
    .DEPTH(DEPTH)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .stat     (stat),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

endmodule

`default_nettype wire
